[rtl/core/ffce_pkg.sv]
`timescale 1ns / 1ps
// ffce_pkg: shared constants, types and register indexes of the comment extractor
// no dependencies

package ffce_pkg;

    localparam int LINE_DIGITS = 5;
    localparam int BCD_W       = 4 * LINE_DIGITS;
    localparam int NUM_CODES   = 5;
    localparam int CODE_W      = 8 * NUM_CODES;
    localparam int PREFIX_LEN  = LINE_DIGITS + 1;
    localparam int TAIL_MAX    = 3;
    localparam int POS_W       = $clog2(LINE_DIGITS + 5);
    localparam int DIGIT_W     = (LINE_DIGITS > 1) ? $clog2(LINE_DIGITS) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CODE_CHARS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_LINES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ONLY   = 2'd2;

    localparam logic [7:0] CH_UPPER_C = 8'h43;
    localparam logic [7:0] CH_LOWER_C = 8'h63;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [3:0] CH_DIGIT_HI = 4'h3;

    typedef struct packed {
        logic [CODE_W-1:0] code_chars;
        logic              number_lines;
        logic              text_only;
    } cfg_t;

    // one queued job: line number snapshot, prefix flag and the bytes after the prefix
    typedef struct packed {
        logic [BCD_W-1:0]            bcd;
        logic                        prefix;
        logic [1:0]                  ntail;
        logic [TAIL_MAX-1:0][7:0]    tail;
    } cmd_t;

endpackage

[rtl/core/ffce_front.sv]
`timescale 1ns / 1ps
// ffce_front: line parser, classifies each input item and queues output jobs
// depends on ffce_pkg

module ffce_front (
    input  logic              clk,
    input  logic              rst_n,
    input  ffce_pkg::cfg_t    cfg,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              end_of_file,
    output logic              push,
    output ffce_pkg::cmd_t    cmd
);
    import ffce_pkg::*;

    typedef enum logic [2:0] {
        PH_LINE_START,
        PH_COL2,
        PH_COL3,
        PH_COPY,
        PH_SKIP
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [7:0]       first_reg, first_next;
    logic             code_hit;
    logic [BCD_W-1:0] bcd_inc;

    function automatic logic [BCD_W-1:0] bcd_step(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        logic             all_nine;
        logic             carry;
        r        = v;
        all_nine = 1'b1;
        carry    = 1'b1;
        for (int i = 0; i < LINE_DIGITS; i++) begin
            if (v[4*i +: 4] != 4'd9)
            begin
                all_nine = 1'b0;
            end
        end
        if (!all_nine)
        begin
            for (int i = 0; i < LINE_DIGITS; i++) begin
                if (carry)
                begin
                    if (v[4*i +: 4] == 4'd9)
                    begin
                        r[4*i +: 4] = 4'd0;
                    end
                    else
                    begin
                        r[4*i +: 4] = v[4*i +: 4] + 4'd1;
                        carry       = 1'b0;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] marker(input logic to, input logic [7:0] b);
        return to ? CH_SPACE : b;
    endfunction

    assign bcd_inc = bcd_step(bcd_reg);

    always_comb
    begin
        code_hit = 1'b0;
        for (int i = 0; i < NUM_CODES; i++) begin
            if (cfg.code_chars[8*i +: 8] == in_byte)
            begin
                code_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        bcd_next   = bcd_reg;
        first_next = first_reg;
        push       = 1'b0;
        cmd.bcd    = bcd_reg;
        cmd.prefix = 1'b0;
        cmd.ntail  = 2'd0;
        cmd.tail   = '0;
        if (accept)
        begin
            if (end_of_file)
            begin
                phase_next = PH_LINE_START;
                bcd_next   = BCD_W'(1);
                first_next = 8'h00;
            end
            else
            begin
                case (phase_reg)
                    PH_LINE_START:
                    begin
                        if (in_byte inside {CH_UPPER_C, CH_LOWER_C, CH_STAR})
                        begin
                            if (cfg.code_chars[7:0] == 8'h00)
                            begin
                                push        = 1'b1;
                                cmd.prefix  = 1'b1;
                                cmd.ntail   = 2'd1;
                                cmd.tail[0] = marker(cfg.text_only, in_byte);
                                phase_next  = PH_COPY;
                            end
                            else
                            begin
                                first_next = in_byte;
                                phase_next = PH_COL2;
                            end
                        end
                        else if (in_byte == CH_NL)
                        begin
                            bcd_next = bcd_inc;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_COL2:
                    begin
                        if (in_byte == CH_SPACE)
                        begin
                            phase_next = PH_COL3;
                        end
                        else if (code_hit)
                        begin
                            push        = 1'b1;
                            cmd.prefix  = 1'b1;
                            cmd.ntail   = 2'd2;
                            cmd.tail[0] = marker(cfg.text_only, first_reg);
                            cmd.tail[1] = marker(cfg.text_only, in_byte);
                            phase_next  = PH_COPY;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_COL3:
                    begin
                        if (code_hit)
                        begin
                            push        = 1'b1;
                            cmd.prefix  = 1'b1;
                            cmd.ntail   = 2'd3;
                            cmd.tail[0] = marker(cfg.text_only, first_reg);
                            cmd.tail[1] = CH_SPACE;
                            cmd.tail[2] = marker(cfg.text_only, in_byte);
                            phase_next  = PH_COPY;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_COPY:
                    begin
                        push        = 1'b1;
                        cmd.ntail   = 2'd1;
                        cmd.tail[0] = in_byte;
                        if (in_byte == CH_NL)
                        begin
                            bcd_next   = bcd_inc;
                            phase_next = PH_LINE_START;
                        end
                    end
                    default:
                    begin
                        if (in_byte == CH_NL)
                        begin
                            bcd_next   = bcd_inc;
                            phase_next = PH_LINE_START;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LINE_START;
            bcd_reg   <= BCD_W'(1);
            first_reg <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            bcd_reg   <= bcd_next;
            first_reg <= first_next;
        end
    end

endmodule

[rtl/core/ffce_queue.sv]
`timescale 1ns / 1ps
// ffce_queue: short job queue between parser and output sequencer
// depends on ffce_pkg

module ffce_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ffce_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output ffce_pkg::cmd_t    head,
    output logic              empty,
    output logic              full
);
    import ffce_pkg::*;

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head  = mem[rd_reg];

    always_comb
    begin
        wr_next  = push ? ptr_inc(wr_reg) : wr_reg;
        rd_next  = pop ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[rtl/core/ffce_back.sv]
`timescale 1ns / 1ps
// ffce_back: output sequencer, expands queued jobs into line number prefix and bytes
// depends on ffce_pkg

module ffce_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ffce_pkg::cfg_t    cfg,
    input  ffce_pkg::cmd_t    q_head,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // out_byte[7:0]
    output logic              m_tlast    // last_of_run
);
    import ffce_pkg::*;

    cmd_t              cur_reg, cur_next;
    logic              busy_reg, busy_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              ovalid_reg, ovalid_next;
    logic [7:0]        odata_reg, odata_next;
    logic              olast_reg, olast_next;

    cmd_t              sel;
    logic              have;
    logic              emit;
    logic              is_last;
    logic [POS_W-1:0]  p;
    logic [POS_W-1:0]  plen;
    logic [POS_W-1:0]  total;
    logic [POS_W-1:0]  tdiff;
    logic [POS_W-1:0]  jpos;
    logic [DIGIT_W-1:0] jidx;
    logic [LINE_DIGITS-1:0] shown;
    logic              nz;
    logic [3:0]        dig;
    logic [7:0]        byte_out;

    assign sel   = busy_reg ? cur_reg : q_head;
    assign have  = busy_reg || !q_empty;
    assign p     = busy_reg ? pos_reg : '0;
    assign plen  = (cfg.number_lines && sel.prefix) ? POS_W'(PREFIX_LEN) : '0;
    assign total = plen + POS_W'(sel.ntail);
    assign emit  = (!ovalid_reg || m_tready) && have;
    assign is_last = (p == total - POS_W'(1));
    assign q_pop = emit && !busy_reg;

    // leading zeros of the line number show as spaces
    always_comb
    begin
        nz = 1'b0;
        for (int j = LINE_DIGITS - 1; j >= 0; j--) begin
            nz       = nz || (sel.bcd[4*j +: 4] != 4'd0) || (j == 0);
            shown[j] = nz;
        end
    end

    assign jpos  = POS_W'(LINE_DIGITS - 1) - p;
    assign jidx  = jpos[DIGIT_W-1:0];
    assign dig   = sel.bcd[4*jidx +: 4];
    assign tdiff = p - plen;

    always_comb
    begin
        if (p < plen && p < POS_W'(LINE_DIGITS))
        begin
            byte_out = shown[jidx] ? {CH_DIGIT_HI, dig} : CH_SPACE;
        end
        else if (p < plen)
        begin
            byte_out = CH_SPACE;
        end
        else
        begin
            byte_out = sel.tail[tdiff[1:0]];
        end
    end

    always_comb
    begin
        cur_next    = cur_reg;
        busy_next   = busy_reg;
        pos_next    = pos_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        if (emit)
        begin
            ovalid_next = 1'b1;
            odata_next  = byte_out;
            olast_next  = is_last;
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                busy_next = 1'b1;
                pos_next  = p + POS_W'(1);
                if (!busy_reg)
                begin
                    cur_next = q_head;
                end
            end
        end
        else if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            pos_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            pos_reg    <= pos_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job taken from empty queue");

    a_busy_pos: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg != '0))
        else $error("job in progress at first position");

    a_busy_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(q_pop))
        else $error("job started without a queue pop");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> m_tvalid)
        else $error("emitted byte not presented");
`endif

endmodule

[rtl/core/fixed_form_comment_extractor_core.sv]
`timescale 1ns / 1ps
// fixed_form_comment_extractor_core: top level, config registers, parser, queue, sequencer
// depends on ffce_pkg, ffce_front, ffce_queue, ffce_back
//
// channel   direction  handshake            payload
// s_*       in         s_tvalid / s_tready  tdata: in_byte, tuser: end_of_file
// m_*       out        m_tvalid / m_tready  tdata: out_byte, tlast: last_of_run
// cfg_*     in         cfg_valid / cfg_ready index 0 code_chars, 1 number_lines, 2 text_only
//
// one input item per cycle while the job queue has room
// output runs one byte per cycle unless m_tready stalls it; an item emits from 0 to 9 bytes,
// so a line number prefix stalls input briefly once the queue fills
// reset clears parser, line number to one, config, queue pointers, tvalid; no clearing pass
// output register parts the sides; m_tready low stalls output, then input once queue is full

module fixed_form_comment_extractor_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // in_byte[7:0]
    input  logic                               s_tuser,   // end_of_file
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // out_byte[7:0]
    output logic                               m_tlast,   // last_of_run
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ffce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ffce_pkg::CODE_W-1:0]        cfg_data
);
    import ffce_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  accept;
    logic  push;
    cmd_t  push_cmd;
    logic  pop;
    cmd_t  head;
    logic  empty;
    logic  full;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CODE_CHARS:   cfg_next.code_chars   = cfg_data;
                REG_NUMBER_LINES: cfg_next.number_lines = cfg_data[0];
                REG_TEXT_ONLY:    cfg_next.text_only    = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ffce_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept      (accept),
        .in_byte     (s_tdata),
        .end_of_file (s_tuser),
        .push        (push),
        .cmd         (push_cmd)
    );

    ffce_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    ffce_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_head   (head),
        .q_empty  (empty),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job queued while queue full");

    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (accept && !s_tuser))
        else $error("job queued without a text item");
`endif

endmodule
